### design/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg - shared constants for the Taylor series sine pipeline
// Field widths, parameter defaults, register map and the 2*pi constant.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Fixed field widths
  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 32;

  // Parameter defaults
  localparam int MAX_TERMS_DEF = 12;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register map: word index taken from paddr[2]
  localparam logic [0:0] REG_EXTRA_TERMS = 1'b0;

  // extra_terms register
  localparam int         EXTRA_TERMS_W   = 4;
  localparam logic [3:0] EXTRA_TERMS_RST = 4'd10;

  // 2*pi in unsigned Q32, rounded down
  localparam longint TWO_PI_Q32 = 64'h0000_0006_487E_D511;

endpackage

### design/taylor_sine_fixed_top.sv
// ----------------------------------------------------------------------------
// taylor_sine_fixed_top - pipelined truncated Taylor series sine
// Clamps a signed fixed point angle to +/-2*pi and sums up to MAX_TERMS odd
// series terms, each term derived from the previous one in two stages.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------
//  angle in  | start, busy, angle_i                    | taken on start & !busy
//  sine out  | done_o, sine_o                          | one-cycle strobe
//  config    | psel, penable, pwrite, paddr, pwdata,   | APB, pready tied high
//            | prdata, pready                          |
//
//  One item enters every cycle; busy stays low.
//  An accepted item passes through the clamp and square stages, then the two
//  multiplier stages per higher-order series term, then the output stage.
//  rst_ni clears all valid bits and loads extra_terms with 10.
//  Results flow out on done_o without back-pressure; the pipeline never holds.
//
module taylor_sine_fixed_top #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Item input
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [tss_pkg::ANGLE_W-1:0]      angle_i,
  // Result output
  output logic                                    done_o,
  output logic signed [tss_pkg::SINE_W-1:0]       sine_o,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic        [tss_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic        [tss_pkg::APB_DATA_W-1:0]   pwdata,
  output logic        [tss_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                    pready
);

  localparam int XW  = tss_pkg::ANGLE_W;          // clamped angle
  localparam int X2W = 32;                        // x squared
  localparam int TW  = 32;                        // series term
  localparam int PW  = FRAC_BITS + 13;            // term * x^2
  localparam int RW  = FRAC_BITS;                 // reciprocal constant
  localparam int SW  = 34;                        // running sum
  localparam int OW  = tss_pkg::SINE_W;
  localparam int NW  = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;
  localparam int ETW = tss_pkg::EXTRA_TERMS_W;
  localparam int LAT = 2 * MAX_TERMS + 1;

  localparam logic signed [XW-1:0] LIM = XW'((tss_pkg::TWO_PI_Q32 +
      (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));
  localparam logic        [ETW-1:0] N_MAX = ETW'(MAX_TERMS - 1);
  localparam logic signed [SW-1:0]  SAT_HI = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0]  SAT_LO = -SW'(64'sh8000_0000);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [ETW-1:0] extra_terms_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == tss_pkg::REG_EXTRA_TERMS);

  // Load extra_terms on a completed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_terms_q <= tss_pkg::EXTRA_TERMS_RST;
    end else if (cfg_wr) begin
      extra_terms_q <= pwdata[ETW-1:0];
    end
  end

  // Return the register on reads of its word, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[2] == tss_pkg::REG_EXTRA_TERMS) begin
      prdata = {{(tss_pkg::APB_DATA_W-ETW){1'b0}}, extra_terms_q};
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 0: clamp angle, limit term count
  // --------------------------------------------------------------------------
  logic              s0_vld_q;
  logic signed [XW-1:0] s0_x_q, s0_x_d;
  logic [NW-1:0]     s0_n_q, s0_n_d;

  always_comb begin
    s0_x_d = angle_i;
    if (angle_i > LIM) begin
      s0_x_d = LIM;
    end else if (angle_i < -LIM) begin
      s0_x_d = -LIM;
    end
    s0_n_d = (extra_terms_q > N_MAX) ? NW'(N_MAX) : NW'(extra_terms_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_x_q <= s0_x_d;
    s0_n_q <= s0_n_d;
  end

  // --------------------------------------------------------------------------
  // Stage 1: square the angle, seed term and sum with x
  // --------------------------------------------------------------------------
  logic                  s1_vld_q;
  logic signed [X2W-1:0] s1_x2_q;
  logic signed [TW-1:0]  s1_term_q;
  logic signed [SW-1:0]  s1_sum_q;
  logic [NW-1:0]         s1_n_q;
  logic signed [2*XW-1:0] sq_full, sq_shift;

  assign sq_full  = s0_x_q * s0_x_q;
  assign sq_shift = sq_full >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x2_q   <= sq_shift[X2W-1:0];
    s1_term_q <= TW'(s0_x_q);
    s1_sum_q  <= {{(SW-XW){s0_x_q[XW-1]}}, s0_x_q};
    s1_n_q    <= s0_n_q;
  end

  // --------------------------------------------------------------------------
  // Term stages: A multiplies by x^2, B by the negated reciprocal of (2k)(2k+1)
  // --------------------------------------------------------------------------
  logic                  a_vld_q  [1:MAX_TERMS-1];
  logic signed [PW-1:0]  a_p_q    [1:MAX_TERMS-1];
  logic signed [X2W-1:0] a_x2_q   [1:MAX_TERMS-1];
  logic signed [SW-1:0]  a_sum_q  [1:MAX_TERMS-1];
  logic [NW-1:0]         a_n_q    [1:MAX_TERMS-1];
  logic                  b_vld_q  [1:MAX_TERMS-1];
  logic signed [TW-1:0]  b_t_q    [1:MAX_TERMS-1];
  logic signed [X2W-1:0] b_x2_q   [1:MAX_TERMS-1];
  logic signed [SW-1:0]  b_sum_q  [1:MAX_TERMS-1];
  logic [NW-1:0]         b_n_q    [1:MAX_TERMS-1];

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
    localparam longint DK = longint'(2 * k) * longint'(2 * k + 1);
    localparam longint RK = ((longint'(1) << FRAC_BITS) + DK / 2) / DK;
    localparam logic signed [RW-1:0] RC = RW'(RK);

    logic                  src_vld;
    logic signed [TW-1:0]  src_term;
    logic signed [X2W-1:0] src_x2;
    logic signed [SW-1:0]  src_sum;
    logic [NW-1:0]         src_n;
    logic signed [TW+X2W-1:0] tx_full, tx_shift;
    logic signed [PW+RW-1:0]  pr_full, pr_shift;

    // Pick up the previous term, folding it into the sum when it counts
    if (k == 1) begin : g_first
      assign src_vld  = s1_vld_q;
      assign src_term = s1_term_q;
      assign src_x2   = s1_x2_q;
      assign src_sum  = s1_sum_q;
      assign src_n    = s1_n_q;
    end else begin : g_next
      logic signed [SW-1:0] prev_t;
      assign prev_t   = (NW'(k - 1) <= b_n_q[k-1]) ?
                        {{(SW-TW){b_t_q[k-1][TW-1]}}, b_t_q[k-1]} : '0;
      assign src_vld  = b_vld_q[k-1];
      assign src_term = b_t_q[k-1];
      assign src_x2   = b_x2_q[k-1];
      assign src_sum  = b_sum_q[k-1] + prev_t;
      assign src_n    = b_n_q[k-1];
    end

    assign tx_full  = src_term * src_x2;
    assign tx_shift = tx_full >>> FRAC_BITS;
    assign pr_full  = a_p_q[k] * RC;
    assign pr_shift = pr_full >>> FRAC_BITS;

    // Advance valid bits
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[k] <= 1'b0;
        b_vld_q[k] <= 1'b0;
      end else begin
        a_vld_q[k] <= src_vld;
        b_vld_q[k] <= a_vld_q[k];
      end
    end

    // Advance payload
    always_ff @(posedge clk_i) begin
      a_p_q[k]   <= tx_shift[PW-1:0];
      a_x2_q[k]  <= src_x2;
      a_sum_q[k] <= src_sum;
      a_n_q[k]   <= src_n;
      b_t_q[k]   <= -TW'(pr_shift);
      b_x2_q[k]  <= a_x2_q[k];
      b_sum_q[k] <= a_sum_q[k];
      b_n_q[k]   <= a_n_q[k];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: add last term, saturate, strobe result
  // --------------------------------------------------------------------------
  logic                 out_vld_q;
  logic signed [OW-1:0] out_sine_q, out_sine_d;
  logic signed [SW-1:0] last_t, fin_sum;

  assign last_t  = (NW'(MAX_TERMS - 1) <= b_n_q[MAX_TERMS-1]) ?
                   {{(SW-TW){b_t_q[MAX_TERMS-1][TW-1]}}, b_t_q[MAX_TERMS-1]} : '0;
  assign fin_sum = b_sum_q[MAX_TERMS-1] + last_t;

  always_comb begin
    out_sine_d = fin_sum[OW-1:0];
    if (fin_sum > SAT_HI) begin
      out_sine_d = SAT_HI[OW-1:0];
    end else if (fin_sum < SAT_LO) begin
      out_sine_d = SAT_LO[OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= b_vld_q[MAX_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_sine_q <= out_sine_d;
  end

  assign done_o = out_vld_q;
  assign sine_o = out_sine_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted item did not complete after fixed latency");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result strobe without matching accepted item");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_vld_q |-> (s0_x_q <= LIM && s0_x_q >= -LIM))
    else $error("clamped angle outside limit");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> extra_terms_q == $past(pwdata[ETW-1:0]))
    else $error("extra_terms not loaded by write");

  a_term_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (s1_n_q <= NW'(MAX_TERMS - 1)))
    else $error("term count above maximum");

endmodule
